/* rtl/tdlm_pkg.sv */
// Package with shared constants and types of the task deadline lease monitor.
`timescale 1ns / 1ps
package tdlm_pkg;
	localparam int TASK_COUNT_DEF = 8;
	localparam logic [30:0] MAX_LEASE_RST = 31'd60000;
	localparam logic [2:0] OP_REGISTER = 3'd0;
	localparam logic [2:0] OP_ARM      = 3'd1;
	localparam logic [2:0] OP_CHECK    = 3'd2;
	localparam logic [2:0] OP_PROGRESS = 3'd3;
	localparam logic [2:0] OP_BEGIN    = 3'd4;
	localparam logic [2:0] OP_END      = 3'd5;
	localparam logic [2:0] OP_STABLE   = 3'd6;
	localparam logic [2:0] OP_NONE     = 3'd7;

	// Request to the shared subtract-and-compare unit.
	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] limit;
	} cmp_req_t;
endpackage

/* rtl/task_deadline_lease_monitor.sv */
// Top level of the task deadline lease monitor.
`timescale 1ns / 1ps
// Watchdog over up to TASK_COUNT tasks. Each command takes one transfer and
// gives one result. A command walks the task slots one at a time through a
// single shared subtract-and-compare unit (request in one cycle, registered
// answer in the next); a stable_for that reaches the duration compare then
// runs one more compare before its result. Register, arm and the unused opcode
// skip the scan, as does a command that fails before it. The block takes no
// command while one is in flight or its result waits.
module task_deadline_lease_monitor #(
	parameter int TASK_COUNT = tdlm_pkg::TASK_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  opcode,
	input  logic [7:0]  task_id,
	input  logic [31:0] value,
	input  logic [31:0] now_ms,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        ok,
	output logic [7:0]  faults,
	output logic        is_stable,
	output logic        is_armed,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [30:0] cfg_data
);
	localparam int IW = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
	localparam logic [2:0] ST_IDLE = 3'd0, ST_REQ = 3'd1, ST_ACK = 3'd2,
		ST_POST = 3'd3, ST_SQRY = 3'd4, ST_SACK = 3'd5, ST_OUT = 3'd6;

	logic [2:0]  state_q;
	logic [2:0]  op_q;
	logic [7:0]  id_q;
	logic [31:0] val_q, now_q;
	logic [IW:0] idx_q;
	logic        allseen_q;
	logic [30:0] max_lease_q;
	logic [7:0]  reg_q, fault_q;
	logic        armed_q, stable_q;
	logic [31:0] hstart_q;
	logic [31:0] beat_q [TASK_COUNT];
	logic [30:0] dl_q   [TASK_COUNT];
	logic [31:0] lbeg_q [TASK_COUNT];
	logic [30:0] llen_q [TASK_COUNT];
	logic [TASK_COUNT-1:0] held_q;
	logic [1:0]  seen_q [TASK_COUNT];

	tdlm_pkg::cmp_req_t req;
	logic ge_q;
	logic [IW-1:0] ix;
	logic [IW-1:0] tid;
	logic id_ok, id_reg, any_held, pre_ok;
	logic [7:0] fault_nx;

	tdlm_cmp u_cmp (.clk(clk), .req(req), .ge_q(ge_q));

	assign ix  = idx_q[IW-1:0];
	assign tid = id_q[IW-1:0];
	assign id_ok  = ({24'd0, id_q} < TASK_COUNT);
	assign id_reg = id_ok && reg_q[id_q[2:0]];
	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign faults    = fault_q;
	assign is_stable = stable_q;
	assign is_armed  = armed_q;

	always_comb begin
		any_held = 1'b0;
		for (int i = 0; i < TASK_COUNT; i++) begin
			if (reg_q[i] && held_q[i]) any_held = 1'b1;
		end
	end

	always_comb begin
		req = '0;
		if (state_q == ST_SQRY) begin
			// The healthy start moves to now when the check makes the block stable.
			req.a = now_q;
			req.b = (allseen_q && !stable_q) ? now_q : hstart_q;
			req.limit = val_q;
		end else if (held_q[ix]) begin
			req.a = now_q;
			req.b = lbeg_q[ix];
			req.limit = {1'b0, llen_q[ix]};
		end else begin
			req.a = now_q;
			req.b = beat_q[ix];
			req.limit = {1'b0, dl_q[ix]};
		end
	end

	// Conditions that a command tests before the check runs.
	always_comb begin
		case (op_q)
			tdlm_pkg::OP_CHECK:    pre_ok = 1'b1;
			tdlm_pkg::OP_PROGRESS: pre_ok = id_reg;
			tdlm_pkg::OP_BEGIN:    pre_ok = id_reg && (val_q != 32'd0) &&
				(val_q <= {1'b0, max_lease_q});
			tdlm_pkg::OP_END:      pre_ok = id_reg && held_q[tid];
			tdlm_pkg::OP_STABLE:   pre_ok = 1'b1;
			default:               pre_ok = 1'b0;
		endcase
	end

	assign fault_nx = fault_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q <= '0;
			id_q <= '0;
			val_q <= '0;
			now_q <= '0;
			max_lease_q <= tdlm_pkg::MAX_LEASE_RST;
			reg_q <= '0;
			fault_q <= '0;
			armed_q <= 1'b0;
			stable_q <= 1'b0;
			hstart_q <= '0;
			held_q <= '0;
			ok <= 1'b0;
			idx_q <= '0;
			allseen_q <= 1'b0;
			for (int i = 0; i < TASK_COUNT; i++) begin
				beat_q[i] <= '0;
				dl_q[i] <= '0;
				lbeg_q[i] <= '0;
				llen_q[i] <= '0;
				seen_q[i] <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cfg_valid) max_lease_q <= cfg_data;
					if (in_valid) begin
						op_q <= opcode;
						id_q <= task_id;
						val_q <= value;
						now_q <= now_ms;
						idx_q <= '0;
						allseen_q <= 1'b1;
						case (opcode)
							tdlm_pkg::OP_REGISTER: begin
								if (!armed_q && ({24'd0, task_id} < TASK_COUNT) &&
									value != 32'd0 && !value[31] &&
									!reg_q[task_id[2:0]]) begin
									beat_q[task_id[IW-1:0]] <= now_ms;
									dl_q[task_id[IW-1:0]] <= value[30:0];
									lbeg_q[task_id[IW-1:0]] <= '0;
									llen_q[task_id[IW-1:0]] <= '0;
									held_q[task_id[IW-1:0]] <= 1'b0;
									seen_q[task_id[IW-1:0]] <= '0;
									reg_q[task_id[2:0]] <= 1'b1;
									ok <= 1'b1;
								end else ok <= 1'b0;
								state_q <= ST_OUT;
							end
							tdlm_pkg::OP_ARM: begin
								if (!armed_q && value[7:0] != 8'd0 &&
									reg_q == value[7:0] && fault_q == 8'd0) begin
									armed_q <= 1'b1;
									stable_q <= 1'b0;
									for (int i = 0; i < TASK_COUNT; i++) begin
										if (reg_q[i]) begin
											beat_q[i] <= now_ms;
											seen_q[i] <= '0;
										end
									end
									ok <= 1'b1;
								end else ok <= 1'b0;
								state_q <= ST_OUT;
							end
							tdlm_pkg::OP_CHECK, tdlm_pkg::OP_PROGRESS,
							tdlm_pkg::OP_BEGIN, tdlm_pkg::OP_END,
							tdlm_pkg::OP_STABLE: begin
								ok <= 1'b0;
								state_q <= ST_POST;
							end
							default: begin
								ok <= 1'b0;
								state_q <= ST_OUT;
							end
						endcase
					end
				end
				ST_POST: begin
					// Fail before the scan when an earlier condition fails or the block is not armed.
					if (!pre_ok || !armed_q) state_q <= ST_OUT;
					else state_q <= ST_REQ;
				end
				ST_REQ: begin
					if (reg_q[ix] && seen_q[ix] < 2'd2) allseen_q <= 1'b0;
					state_q <= ST_ACK;
				end
				ST_ACK: begin
					if (reg_q[ix] && ge_q) fault_q[ix] <= 1'b1;
					if (idx_q == (IW + 1)'(TASK_COUNT - 1)) state_q <= ST_SQRY;
					else begin
						idx_q <= idx_q + 1'b1;
						state_q <= ST_REQ;
					end
				end
				ST_SQRY: begin
					// Finish the check, then apply the command.
					if (fault_nx == 8'd0 && op_q == tdlm_pkg::OP_STABLE &&
						(stable_q || allseen_q) && !val_q[31] && !any_held)
						state_q <= ST_SACK;
					else state_q <= ST_OUT;
					if (fault_nx != 8'd0) stable_q <= 1'b0;
					else begin
						if (allseen_q && !stable_q) begin
							stable_q <= 1'b1;
							hstart_q <= now_q;
						end
						case (op_q)
							tdlm_pkg::OP_CHECK: ok <= 1'b1;
							tdlm_pkg::OP_PROGRESS: if (!held_q[tid]) begin
								beat_q[tid] <= now_q;
								if (seen_q[tid] < 2'd2) seen_q[tid] <= seen_q[tid] + 2'd1;
								ok <= 1'b1;
							end
							tdlm_pkg::OP_BEGIN: if (!held_q[tid]) begin
								lbeg_q[tid] <= now_q;
								llen_q[tid] <= val_q[30:0];
								held_q[tid] <= 1'b1;
								ok <= 1'b1;
							end
							tdlm_pkg::OP_END: begin
								beat_q[tid] <= now_q;
								held_q[tid] <= 1'b0;
								if (seen_q[tid] < 2'd2) seen_q[tid] <= seen_q[tid] + 2'd1;
								ok <= 1'b1;
							end
							default: ;
						endcase
					end
				end
				ST_SACK: begin
					// The compare ran on the updated healthy start in the previous cycle.
					ok <= ge_q;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_stall) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

/* rtl/tdlm_cmp.sv */
// Shared unit: registered test of (a - b) modulo 2^32 against a limit.
`timescale 1ns / 1ps
module tdlm_cmp (
	input  logic              clk,
	input  tdlm_pkg::cmp_req_t req,
	output logic              ge_q
);
	logic [31:0] diff;
	assign diff = req.a - req.b;
	always_ff @(posedge clk) begin
		ge_q <= (diff >= req.limit);
	end
endmodule
